[rtl/ptt_pkg.sv]
package ptt_pkg;

  localparam int SLOT_W     = 4;
  localparam int RESULT_CAP = 16;
  localparam int CAP_W      = $clog2(RESULT_CAP + 1);

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_DEL  = 2'd2;
  localparam logic [1:0] KIND_DISP = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOO_MANY  = 2'd1;
  localparam logic [1:0] ERR_NO_DELETE = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       initial_delay;
    logic [15:0]       period;
  } ptt_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [7:0]        run_count;
    logic [1:0]        last_error;
    logic              last;
  } ptt_out_t;

  typedef struct packed {
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
  } ptt_entry_t;

endpackage

[rtl/periodic_task_tick_table_top.sv]
// Task slot table of a time-triggered cooperative scheduler. Requests are
// handled one at a time; in_stall_o is high while a request is at work.
// Slot delay, period and pending-run count live in one memory with a
// registered read; occupied flags are flip-flops cleared by reset, so no
// clearing pass is needed. A tick walks every slot through the memory at
// one slot per cycle, read and write-back overlapped. An add scans the
// occupied flags one slot per cycle. A dispatch returns one result per
// occupied slot with pending runs, capped at sixteen results, and waits
// while the result side stalls. Results go out through an output
// register, so the next request is taken while a result still waits.
module periodic_task_tick_table_top import ptt_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ptt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ptt_out_t out_data_o
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int EXT_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_TICK     = 6'b000010,
    S_ADD      = 6'b000100,
    S_DISP_RD  = 6'b001000,
    S_DISP_CHK = 6'b010000,
    S_FLUSH    = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic [CAP_W-1:0]     cnt_q, cnt_d;
  logic [MAX_TASKS-1:0] occ_q, occ_d;
  logic [1:0]           err_q, err_d;
  logic                 hold_vld_q, hold_vld_d;
  logic                 stg_vld_q, stg_vld_d;
  ptt_out_t             hold_q, hold_d;
  logic [15:0]          dly_q, per_q;

  logic                 mem_re, mem_we;
  logic [IDX_W-1:0]     mem_raddr, mem_waddr;
  ptt_entry_t           mem_rdata, mem_wdata;

  logic                 push;
  ptt_out_t             push_data;
  logic                 out_free;

  logic [CNT_W-1:0]     prev_ptr;
  logic [IDX_W-1:0]     ptr_idx, prev_idx, del_idx;
  logic [EXT_W-1:0]     slot_ext;
  logic                 ptr_end, del_in_range, del_empty;

  assign in_stall_o   = (state_q != S_IDLE);
  assign ptr_end      = (ptr_q == CNT_W'(MAX_TASKS));
  assign ptr_idx      = ptr_q[IDX_W-1:0];
  assign prev_ptr     = ptr_q - 1'b1;
  assign prev_idx     = prev_ptr[IDX_W-1:0];
  assign slot_ext     = EXT_W'(in_data_i.slot);
  assign del_idx      = slot_ext[IDX_W-1:0];
  assign del_in_range = (slot_ext < EXT_W'(MAX_TASKS));
  assign del_empty    = !del_in_range || !occ_q[del_idx];

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    occ_d      = occ_q;
    err_d      = err_q;
    hold_vld_d = hold_vld_q;
    stg_vld_d  = stg_vld_q;
    hold_d     = hold_q;
    mem_re     = 1'b0;
    mem_raddr  = ptr_idx;
    mem_we     = 1'b0;
    mem_waddr  = ptr_idx;
    mem_wdata  = mem_rdata;
    push       = 1'b0;
    push_data  = hold_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.kind)
            KIND_TICK: begin
              ptr_d     = '0;
              stg_vld_d = 1'b0;
              state_d   = S_TICK;
            end
            KIND_ADD: begin
              ptr_d   = '0;
              state_d = S_ADD;
            end
            KIND_DEL: begin
              if (del_empty) begin
                err_d = ERR_NO_DELETE;
              end
              if (del_in_range) begin
                occ_d[del_idx] = 1'b0;
              end
              hold_d     = '{status: del_empty ? ST_EMPTY : ST_OK,
                             slot_index: in_data_i.slot, run_count: '0,
                             last_error: ERR_NONE, last: 1'b1};
              hold_vld_d = 1'b1;
              state_d    = S_FLUSH;
            end
            KIND_DISP: begin
              ptr_d      = '0;
              cnt_d      = '0;
              hold_vld_d = 1'b0;
              state_d    = S_DISP_RD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_TICK: begin
        if (!ptr_end) begin
          mem_re    = 1'b1;
          ptr_d     = ptr_q + 1'b1;
          stg_vld_d = 1'b1;
        end else begin
          stg_vld_d = 1'b0;
        end
        if (stg_vld_q && occ_q[prev_idx]) begin
          mem_we    = 1'b1;
          mem_waddr = prev_idx;
          if (mem_rdata.delay == 16'd0) begin
            if (mem_rdata.pending != 8'hff) begin
              mem_wdata.pending = mem_rdata.pending + 8'd1;
            end
            if (mem_rdata.period != 16'd0) begin
              mem_wdata.delay = mem_rdata.period;
            end
          end else begin
            mem_wdata.delay = mem_rdata.delay - 16'd1;
          end
        end
        if (ptr_end && !stg_vld_q) begin
          hold_d     = '{status: ST_OK, slot_index: '0, run_count: '0,
                         last_error: ERR_NONE, last: 1'b1};
          hold_vld_d = 1'b1;
          state_d    = S_FLUSH;
        end
      end

      S_ADD: begin
        if (ptr_end) begin
          err_d      = ERR_TOO_MANY;
          hold_d     = '{status: ST_FULL, slot_index: '0, run_count: '0,
                         last_error: ERR_NONE, last: 1'b1};
          hold_vld_d = 1'b1;
          state_d    = S_FLUSH;
        end else if (!occ_q[ptr_idx]) begin
          mem_we         = 1'b1;
          mem_wdata      = '{delay: dly_q, period: per_q, pending: '0};
          occ_d[ptr_idx] = 1'b1;
          hold_d         = '{status: ST_OK, slot_index: SLOT_W'(ptr_q),
                             run_count: '0, last_error: ERR_NONE, last: 1'b1};
          hold_vld_d     = 1'b1;
          state_d        = S_FLUSH;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_DISP_RD: begin
        if (ptr_end) begin
          state_d = S_FLUSH;
        end else if (!occ_q[ptr_idx]) begin
          ptr_d = ptr_q + 1'b1;
        end else begin
          mem_re  = 1'b1;
          state_d = S_DISP_CHK;
        end
      end

      S_DISP_CHK: begin
        if (mem_rdata.pending == 8'd0) begin
          ptr_d   = ptr_q + 1'b1;
          state_d = S_DISP_RD;
        end else if (!hold_vld_q || out_free) begin
          mem_we            = 1'b1;
          mem_wdata.pending = '0;
          if (mem_rdata.period == 16'd0) begin
            occ_d[ptr_idx] = 1'b0;
          end
          push       = hold_vld_q;
          hold_d     = '{status: ST_OK, slot_index: SLOT_W'(ptr_q),
                         run_count: mem_rdata.pending, last_error: ERR_NONE,
                         last: 1'b0};
          hold_vld_d = 1'b1;
          cnt_d      = cnt_q + 1'b1;
          ptr_d      = ptr_q + 1'b1;
          if (cnt_q == CAP_W'(RESULT_CAP - 1)) begin
            state_d = S_FLUSH;
          end else begin
            state_d = S_DISP_RD;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          push = 1'b1;
          if (!hold_vld_q) begin
            push_data = '{status: ST_NONE, slot_index: '0, run_count: '0,
                          last_error: ERR_NONE, last: 1'b1};
          end
          push_data.last = 1'b1;
          hold_vld_d     = 1'b0;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    push_data.last_error = err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ptr_q      <= '0;
      cnt_q      <= '0;
      occ_q      <= '0;
      err_q      <= ERR_NONE;
      hold_vld_q <= 1'b0;
      stg_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      cnt_q      <= cnt_d;
      occ_q      <= occ_d;
      err_q      <= err_d;
      hold_vld_q <= hold_vld_d;
      stg_vld_q  <= stg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    if (in_valid_i && (state_q == S_IDLE)) begin
      dly_q <= in_data_i.initial_delay;
      per_q <= in_data_i.period;
    end
  end

  ptt_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  ptt_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (push_data),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/ptt_mem.sv]
module ptt_mem import ptt_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output ptt_entry_t    rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  ptt_entry_t    wdata_i
);

  ptt_entry_t mem_q [DEPTH];
  ptt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ptt_outreg.sv]
module ptt_outreg import ptt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ptt_out_t data_i,
  output logic     free_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ptt_out_t out_data_o
);

  logic     valid_q;
  ptt_out_t data_q;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/ptt_checker.sv]
module ptt_checker import ptt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input ptt_out_t out_data_o
);

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one still at work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_none_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_NONE) |->
      out_data_o.last && (out_data_o.run_count == 8'd0) &&
      (out_data_o.slot_index == '0))
    else $error("nothing-due result malformed");

  a_err_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.status == ST_FULL) ||
                    (out_data_o.status == ST_EMPTY)) |->
      ((out_data_o.status == ST_FULL) && (out_data_o.last_error == ERR_TOO_MANY)) ||
      ((out_data_o.status == ST_EMPTY) && (out_data_o.last_error == ERR_NO_DELETE)))
    else $error("error status without matching sticky error");

endmodule

bind periodic_task_tick_table_top ptt_checker u_ptt_checker (.*);

[sim/tb.sv]
package ptt_tb_pkg;
  import ptt_pkg::*;

  localparam int NSLOTS = 16;

  class sched_scoreboard;
    logic        busy[NSLOTS];
    logic [15:0] countdown[NSLOTS];
    logic [15:0] reload[NSLOTS];
    logic [7:0]  runs[NSLOTS];
    logic [1:0]  err_code;
    ptt_out_t    awaited[$];
    int          errors;

    function new();
      for (int s = 0; s < NSLOTS; s++) free_slot(s);
      err_code = ERR_NONE;
      errors = 0;
    endfunction

    function void free_slot(int s);
      busy[s] = 1'b0;
      countdown[s] = 16'd0;
      reload[s] = 16'd0;
      runs[s] = 8'd0;
    endfunction

    // predicts the results of one accepted request and updates the table
    function void note_request(ptt_in_t req);
      ptt_out_t res;
      int s;
      int n;
      res = '0;
      res.status = ST_OK;
      res.last = 1'b1;
      case (req.kind)
        KIND_TICK: begin
          for (s = 0; s < NSLOTS; s++) begin
            if (busy[s]) begin
              if (countdown[s] == 16'd0) begin
                if (runs[s] != 8'hff) runs[s] = runs[s] + 8'd1;
                if (reload[s] != 16'd0) countdown[s] = reload[s];
              end else begin
                countdown[s] = countdown[s] - 16'd1;
              end
            end
          end
        end
        KIND_ADD: begin
          s = 0;
          while (s < NSLOTS && busy[s]) s++;
          if (s == NSLOTS) begin
            err_code = ERR_TOO_MANY;
            res.status = ST_FULL;
          end else begin
            busy[s] = 1'b1;
            countdown[s] = req.initial_delay;
            reload[s] = req.period;
            runs[s] = 8'd0;
            res.slot_index = SLOT_W'(s);
          end
        end
        KIND_DEL: begin
          res.slot_index = req.slot;
          if (int'(req.slot) >= NSLOTS || !busy[req.slot]) begin
            err_code = ERR_NO_DELETE;
            res.status = ST_EMPTY;
          end
          if (int'(req.slot) < NSLOTS) free_slot(int'(req.slot));
        end
        default: begin
          n = 0;
          res.last_error = err_code;
          for (s = 0; s < NSLOTS && n < RESULT_CAP; s++) begin
            if (runs[s] != 8'd0) begin
              res.slot_index = SLOT_W'(s);
              res.run_count = runs[s];
              res.last = 1'b0;
              awaited.push_back(res);
              n++;
              runs[s] = 8'd0;
              if (reload[s] == 16'd0) free_slot(s);
            end
          end
          if (n == 0) begin
            res.status = ST_NONE;
          end else begin
            res = awaited.pop_back();
            res.last = 1'b1;
          end
        end
      endcase
      res.last_error = err_code;
      awaited.push_back(res);
    endfunction

    task check_result(ptt_out_t got);
      ptt_out_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result %h with nothing awaited", got));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.slot_index !== want.slot_index)
        report($sformatf("slot_index %0d, want %0d", got.slot_index, want.slot_index));
      if (got.run_count !== want.run_count)
        report($sformatf("run_count %0d, want %0d", got.run_count, want.run_count));
      if (got.last_error !== want.last_error)
        report($sformatf("last_error %0d, want %0d", got.last_error, want.last_error));
      if (got.last !== want.last)
        report($sformatf("last %0d, want %0d", got.last, want.last));
    endtask

    task report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask
  endclass

endpackage

module tb;
  import ptt_pkg::*;
  import ptt_tb_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int N_ITEMS = 430;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ptt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ptt_out_t out_data;

  sched_scoreboard board;

  int   n_sent = 0;
  int   burst_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;
  int   run_left = 0;
  logic run_hold = 1'b0;

  periodic_task_tick_table_top #(.MAX_TASKS(NSLOTS)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) board.check_result(out_data);
    if (in_valid && !in_stall) board.note_request(in_data);
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(40, 300);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: begin
        if (run_left == 0) begin
          run_hold = ~run_hold;
          run_left = $urandom_range(1, 20);
        end
        run_left--;
        out_stall <= run_hold;
      end
    endcase
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("tb: errors");
    $finish;
  end

  // sends one request, with bursts and gaps on the way
  task automatic issue(input int kind, input int slot, input int dly, input int per);
    ptt_in_t req;
    int gap;
    req.kind = 2'(kind);
    req.slot = SLOT_W'(slot);
    req.initial_delay = 16'(dly);
    req.period = 16'(per);
    n_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic int rand_delay();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom_range(0, 4);
    if (pick < 9) return $urandom_range(0, 40);
    return $urandom_range(0, 65535);
  endfunction

  function automatic int rand_period();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return 0;
    if (pick < 8) return $urandom_range(1, 6);
    return $urandom_range(0, 65535);
  endfunction

  // adds past the last free slot
  task automatic fill_table();
    int free_cnt;
    free_cnt = 0;
    for (int s = 0; s < NSLOTS; s++) if (!board.busy[s]) free_cnt++;
    repeat (free_cnt + $urandom_range(2, 3))
      issue(KIND_ADD, $urandom, rand_delay(), rand_period());
  endtask

  task automatic clear_table();
    for (int s = 0; s < NSLOTS; s++)
      if (board.busy[s] || $urandom_range(0, 3) == 0)
        issue(KIND_DEL, s, $urandom, $urandom);
    issue(KIND_DISP, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int stop_at;
    int k;
    int s;
    rst_n <= 1'b0;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, corner delays and periods, delete of full and empty slots
    issue(KIND_DISP, $urandom, $urandom, $urandom);
    issue(KIND_DEL, 15, $urandom, $urandom);
    issue(KIND_TICK, $urandom, $urandom, $urandom);
    issue(KIND_ADD, $urandom, 0, 0);
    issue(KIND_ADD, $urandom, 0, 1);
    issue(KIND_ADD, $urandom, 16'hffff, 16'hffff);
    issue(KIND_ADD, $urandom, 1, 0);
    repeat (2) issue(KIND_TICK, $urandom, $urandom, $urandom);
    issue(KIND_DISP, $urandom, $urandom, $urandom);
    repeat (2) issue(KIND_DEL, 2, $urandom, $urandom);
    issue(KIND_DEL, 1, $urandom, $urandom);
    issue(KIND_DISP, $urandom, $urandom, $urandom);

    fill_table();
    clear_table();

    // one-shot slot at zero delay counts runs up to saturation
    issue(KIND_ADD, $urandom, 0, 0);
    repeat (260) issue(KIND_TICK, $urandom, $urandom, $urandom);
    issue(KIND_DISP, $urandom, $urandom, $urandom);

    stop_at = N_ITEMS;
    while (n_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: fill_table();
        1: clear_table();
        2, 3, 4, 5: begin
          repeat ($urandom_range(8, 25)) begin
            k = $urandom_range(0, 19);
            if (k < 8) begin
              issue(KIND_TICK, $urandom, $urandom, $urandom);
            end else if (k < 12) begin
              issue(KIND_ADD, $urandom, rand_delay(), rand_period());
            end else if (k < 15) begin
              s = $urandom_range(0, NSLOTS - 1);
              if ($urandom_range(0, 9) < 7) begin
                for (int i = 0; i < NSLOTS; i++) begin
                  if (board.busy[(s + i) % NSLOTS]) begin
                    s = (s + i) % NSLOTS;
                    break;
                  end
                end
              end
              issue(KIND_DEL, s, $urandom, $urandom);
            end else begin
              issue(KIND_DISP, $urandom, $urandom, $urandom);
            end
          end
        end
        6: begin
          repeat ($urandom_range(3, 8))
            issue($urandom_range(0, 3), $urandom, $urandom, $urandom);
        end
        default: begin
          repeat ($urandom_range(1, 30)) issue(KIND_TICK, $urandom, $urandom, $urandom);
          issue(KIND_DISP, $urandom, $urandom, $urandom);
        end
      endcase
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ptt_pkg.sv
rtl/ptt_mem.sv
rtl/ptt_outreg.sv
rtl/periodic_task_tick_table_top.sv
rtl/ptt_checker.sv
sim/tb.sv
